[rtl/spcm_pkg.sv]
// spcm_pkg: shared types and constants of the segmented correlation block
// no dependencies; imported by every module under rtl
package spcm_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_SEGMENT = 4096;
    localparam int LEN_W       = 13;
    localparam int STRIDE_W    = 12;
    localparam int CNT_W       = 13;
    localparam int POS_W       = 12;
    localparam int SX_W        = 29;
    localparam int SXX_W       = 43;
    localparam int SXY_W       = 44;
    localparam int IDX_W       = 16;
    localparam int CORR_W      = 16;
    localparam int OP_W        = 57;
    localparam int PROD_W      = 2 * OP_W;
    localparam int ACC_W       = PROD_W + 2;
    localparam int FRAC_SHIFT  = 30;
    localparam int DIV_W       = PROD_W + FRAC_SHIFT;
    localparam int QD_W        = FRAC_SHIFT + 1;
    localparam int Q_W         = 16;
    localparam int STEP_W      = 5;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [LEN_W-1:0]          LEN_RESET = LEN_W'(256);
    localparam logic signed [CORR_W-1:0] CORR_MIN  = {1'b1, {(CORR_W-1){1'b0}}};
    localparam logic signed [CORR_W-1:0] CORR_MAX  = {1'b0, {(CORR_W-1){1'b1}}};

    // one input sample pair
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] x_sample;
        logic signed [SAMPLE_BITS-1:0] y_sample;
        logic                          last_of_record;
    } t_in;

    // one result
    typedef struct packed {
        logic                     segment_valid;
        logic signed [CORR_W-1:0] correlation;
        logic                     degenerate;
        logic [IDX_W-1:0]         segment_index;
        logic signed [CORR_W-1:0] max_correlation;
        logic                     record_done;
    } t_out;

    // work handed from the accumulators to the correlation engine
    typedef struct packed {
        logic                    seg;
        logic                    last;
        logic [IDX_W-1:0]        index;
        logic [CNT_W-1:0]        count;
        logic signed [SX_W-1:0]  sum_x;
        logic signed [SX_W-1:0]  sum_y;
        logic signed [SXX_W-1:0] sum_xx;
        logic signed [SXX_W-1:0] sum_yy;
        logic signed [SXY_W-1:0] sum_xy;
    } t_job;

    // serial multiply steps of the engine
    typedef enum logic [2:0] {
        OP_NXX  = 3'd0,
        OP_SX2  = 3'd1,
        OP_NYY  = 3'd2,
        OP_SY2  = 3'd3,
        OP_NXY  = 3'd4,
        OP_SXY  = 3'd5,
        OP_VXY  = 3'd6,
        OP_COV2 = 3'd7
    } t_op;

endpackage

[rtl/spcm_front.sv]
// spcm_front: takes sample pairs, keeps the two overlapping accumulator sets
// and emits a job when a segment completes or a record ends; uses spcm_pkg
module spcm_front
    import spcm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [LEN_W-1:0]    i_len,
    input  logic [STRIDE_W-1:0] i_stride,
    input  logic                i_valid,
    output logic                o_ready,
    input  t_in                 i_data,
    input  logic                i_full,
    output logic                o_push,
    output t_job                o_job
);

    logic [CNT_W-1:0]        r_cnt  [2];
    logic signed [SX_W-1:0]  r_sx   [2];
    logic signed [SX_W-1:0]  r_sy   [2];
    logic signed [SXX_W-1:0] r_sxx  [2];
    logic signed [SXX_W-1:0] r_syy  [2];
    logic signed [SXY_W-1:0] r_sxy  [2];
    logic [CNT_W-1:0]        n_cnt  [2];
    logic signed [SX_W-1:0]  n_sx   [2];
    logic signed [SX_W-1:0]  n_sy   [2];
    logic signed [SXX_W-1:0] n_sxx  [2];
    logic signed [SXX_W-1:0] n_syy  [2];
    logic signed [SXY_W-1:0] n_sxy  [2];
    logic [POS_W-1:0]        r_pos;
    logic [IDX_W-1:0]        r_segctr;
    logic signed [2*SAMPLE_BITS-1:0] w_pxx, w_pyy, w_pxy;
    logic [1:0]              w_act;
    logic                    w_accept, w_seg, w_sel;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && !i_full;

    // sample products
    assign w_pxx = i_data.x_sample * i_data.x_sample;
    assign w_pyy = i_data.y_sample * i_data.y_sample;
    assign w_pxy = i_data.x_sample * i_data.y_sample;

    // second set starts one stride into the record
    assign w_act[0] = 1'b1;
    assign w_act[1] = (r_pos >= i_stride);

    // updated sums of both sets
    always_comb begin
        for (int b = 0; b < 2; b++) begin
            n_cnt[b] = r_cnt[b] + CNT_W'(w_act[b]);
            n_sx[b]  = w_act[b] ? r_sx[b] + SX_W'(i_data.x_sample) : r_sx[b];
            n_sy[b]  = w_act[b] ? r_sy[b] + SX_W'(i_data.y_sample) : r_sy[b];
            n_sxx[b] = w_act[b] ? r_sxx[b] + SXX_W'(w_pxx) : r_sxx[b];
            n_syy[b] = w_act[b] ? r_syy[b] + SXX_W'(w_pyy) : r_syy[b];
            n_sxy[b] = w_act[b] ? r_sxy[b] + SXY_W'(w_pxy) : r_sxy[b];
        end
    end

    // completion: set 0 wins when both finish together
    assign w_seg = (n_cnt[0] >= i_len) || (n_cnt[1] >= i_len);
    assign w_sel = !(n_cnt[0] >= i_len);

    assign o_push = w_accept && (w_seg || i_data.last_of_record);

    always_comb begin
        o_job.seg    = w_seg;
        o_job.last   = i_data.last_of_record;
        o_job.index  = r_segctr;
        o_job.count  = n_cnt[w_sel];
        o_job.sum_x  = n_sx[w_sel];
        o_job.sum_y  = n_sy[w_sel];
        o_job.sum_xx = n_sxx[w_sel];
        o_job.sum_yy = n_syy[w_sel];
        o_job.sum_xy = n_sxy[w_sel];
    end

    // accumulator sets and record position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_accept && i_data.last_of_record)) begin
            for (int b = 0; b < 2; b++) begin
                r_cnt[b] <= '0;
                r_sx[b]  <= '0;
                r_sy[b]  <= '0;
                r_sxx[b] <= '0;
                r_syy[b] <= '0;
                r_sxy[b] <= '0;
            end
            r_pos    <= '0;
            r_segctr <= '0;
        end else if (w_accept) begin
            for (int b = 0; b < 2; b++) begin
                if (w_seg && (w_sel == b[0])) begin
                    r_cnt[b] <= '0;
                    r_sx[b]  <= '0;
                    r_sy[b]  <= '0;
                    r_sxx[b] <= '0;
                    r_syy[b] <= '0;
                    r_sxy[b] <= '0;
                end else begin
                    r_cnt[b] <= n_cnt[b];
                    r_sx[b]  <= n_sx[b];
                    r_sy[b]  <= n_sy[b];
                    r_sxx[b] <= n_sxx[b];
                    r_syy[b] <= n_syy[b];
                    r_sxy[b] <= n_sxy[b];
                end
            end
            if (r_pos != {POS_W{1'b1}}) begin
                r_pos <= r_pos + POS_W'(1);
            end
            if (w_seg) begin
                r_segctr <= r_segctr + IDX_W'(1);
            end
        end
    end

endmodule

[rtl/spcm_queue.sv]
// spcm_queue: short job queue between the accumulators and the engine
// depends on spcm_pkg for the job type and depth
module spcm_queue
    import spcm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    input  logic i_pop,
    output t_job o_data,
    output logic o_empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NUM_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [NUM_W-1:0] r_num;

    assign o_full  = (r_num == NUM_W'(QUEUE_DEPTH));
    assign o_empty = (r_num == '0);
    assign o_data  = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_num <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_num <= r_num + NUM_W'(1);
            end else if (i_pop && !i_push) begin
                r_num <= r_num - NUM_W'(1);
            end
        end
    end

endmodule

[rtl/spcm_back.sv]
// spcm_back: correlation engine with serial multiplier, divider and root,
// running maximum and output register; depends on spcm_pkg
module spcm_back
    import spcm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_empty,
    output logic o_pop,
    input  t_job i_job,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_SQRT = 5'b01000,
        ST_OUT  = 5'b10000
    } t_state;

    t_state                   r_state;
    t_job                     r_job;
    t_op                      r_op;
    logic [PROD_W-1:0]        r_ma;
    logic [OP_W-1:0]          r_mb;
    logic                     r_sub;
    logic signed [ACC_W-1:0]  r_acc;
    logic [OP_W-1:0]          r_vx, r_vy, r_cov;
    logic                     r_cneg;
    logic [PROD_W-1:0]        r_p;
    logic [DIV_W-1:0]         r_rem, r_pd;
    logic [QD_W-1:0]          r_qd;
    logic [STEP_W-1:0]        r_k;
    logic [Q_W-1:0]           r_q;
    logic                     r_degen;
    logic signed [CORR_W-1:0] r_max;
    logic                     r_ovalid;
    t_out                     r_odata;

    t_job                     w_src;
    t_op                      w_next;
    logic [OP_W-1:0]          w_a, w_b;
    logic                     w_sub, w_clear;
    logic signed [ACC_W-1:0]  w_acc_abs;
    logic                     w_ge;
    logic [Q_W-1:0]           w_t;
    logic [2*Q_W-1:0]         w_sq;
    logic signed [CORR_W-1:0] w_corr, w_newmax;
    logic                     w_free;

    function automatic logic [SXY_W-1:0] mag(input logic signed [SXY_W-1:0] v);
        mag = v[SXY_W-1] ? SXY_W'(-v) : SXY_W'(v);
    endfunction

    assign o_pop   = (r_state == ST_IDLE) && !i_empty;
    assign o_valid = r_ovalid;
    assign o_data  = r_odata;
    assign w_free  = !r_ovalid || i_ready;

    // operands of the next multiply step
    assign w_src  = (r_state == ST_IDLE) ? i_job : r_job;
    assign w_next = (r_state == ST_IDLE) ? OP_NXX : t_op'(r_op + 3'd1);

    always_comb begin
        w_a     = '0;
        w_b     = '0;
        w_sub   = 1'b0;
        w_clear = 1'b0;
        case (w_next)
            OP_NXX: begin
                w_a     = OP_W'(w_src.count);
                w_b     = OP_W'($unsigned(w_src.sum_xx));
                w_clear = 1'b1;
            end
            OP_SX2: begin
                w_a   = OP_W'(mag(SXY_W'(w_src.sum_x)));
                w_b   = OP_W'(mag(SXY_W'(w_src.sum_x)));
                w_sub = 1'b1;
            end
            OP_NYY: begin
                w_a     = OP_W'(w_src.count);
                w_b     = OP_W'($unsigned(w_src.sum_yy));
                w_clear = 1'b1;
            end
            OP_SY2: begin
                w_a   = OP_W'(mag(SXY_W'(w_src.sum_y)));
                w_b   = OP_W'(mag(SXY_W'(w_src.sum_y)));
                w_sub = 1'b1;
            end
            OP_NXY: begin
                w_a     = OP_W'(w_src.count);
                w_b     = OP_W'(mag(w_src.sum_xy));
                w_sub   = w_src.sum_xy[SXY_W-1];
                w_clear = 1'b1;
            end
            OP_SXY: begin
                w_a   = OP_W'(mag(SXY_W'(w_src.sum_x)));
                w_b   = OP_W'(mag(SXY_W'(w_src.sum_y)));
                w_sub = (w_src.sum_x[SX_W-1] == w_src.sum_y[SX_W-1]);
            end
            OP_VXY: begin
                w_a     = r_vx;
                w_b     = r_vy;
                w_clear = 1'b1;
            end
            OP_COV2: begin
                w_a     = r_cov;
                w_b     = r_cov;
                w_clear = 1'b1;
            end
            default: begin
                w_a = '0;
            end
        endcase
    end

    assign w_acc_abs = r_acc[ACC_W-1] ? -r_acc : r_acc;

    // divider and root steps
    assign w_ge = (r_pd <= r_rem);
    assign w_t  = r_q | (Q_W'(1) << r_k[3:0]);
    assign w_sq = w_t * w_t;

    // signed Q1.15 result
    always_comb begin
        if (r_degen) begin
            w_corr = '0;
        end else if (r_cneg) begin
            w_corr = CORR_W'(-$signed({1'b0, r_q}));
        end else if (r_q > Q_W'(CORR_MAX)) begin
            w_corr = CORR_MAX;
        end else begin
            w_corr = $signed(r_q);
        end
    end

    assign w_newmax = (r_job.seg && !r_degen && (w_corr > r_max)) ? w_corr : r_max;

    // sequencer and datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_max    <= CORR_MIN;
            r_ovalid <= 1'b0;
        end else begin
            if ((r_state == ST_OUT) && w_free) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_job   <= i_job;
                        r_degen <= 1'b0;
                        r_cneg  <= 1'b0;
                        r_q     <= '0;
                        if (i_job.seg) begin
                            r_op    <= w_next;
                            r_ma    <= PROD_W'(w_a);
                            r_mb    <= w_b;
                            r_sub   <= w_sub;
                            r_acc   <= '0;
                            r_state <= ST_MUL;
                        end else begin
                            r_state <= ST_OUT;
                        end
                    end
                end
                ST_MUL: begin
                    if (r_mb != '0) begin
                        if (r_mb[0]) begin
                            r_acc <= r_sub ? r_acc - $signed({2'b00, r_ma})
                                           : r_acc + $signed({2'b00, r_ma});
                        end
                        r_ma <= r_ma << 1;
                        r_mb <= r_mb >> 1;
                    end else if (r_op == OP_COV2) begin
                        r_rem   <= {r_acc[PROD_W-1:0], {FRAC_SHIFT{1'b0}}};
                        r_pd    <= {r_p, {FRAC_SHIFT{1'b0}}};
                        r_qd    <= '0;
                        r_k     <= STEP_W'(FRAC_SHIFT);
                        r_state <= ST_DIV;
                    end else if ((r_op == OP_SXY) && ((r_vx == '0) || (r_vy == '0))) begin
                        r_degen <= 1'b1;
                        r_state <= ST_OUT;
                    end else begin
                        case (r_op)
                            OP_SX2: r_vx <= r_acc[OP_W-1:0];
                            OP_SY2: r_vy <= r_acc[OP_W-1:0];
                            OP_SXY: begin
                                r_cov  <= w_acc_abs[OP_W-1:0];
                                r_cneg <= r_acc[ACC_W-1];
                            end
                            OP_VXY: r_p <= r_acc[PROD_W-1:0];
                            default: begin
                                r_p <= r_p;
                            end
                        endcase
                        r_op  <= w_next;
                        r_ma  <= PROD_W'(w_a);
                        r_mb  <= w_b;
                        r_sub <= w_sub;
                        if (w_clear) begin
                            r_acc <= '0;
                        end
                    end
                end
                ST_DIV: begin
                    if (w_ge) begin
                        r_rem <= r_rem - r_pd;
                    end
                    r_qd <= {r_qd[QD_W-2:0], w_ge};
                    r_pd <= r_pd >> 1;
                    if (r_k == '0) begin
                        r_q     <= '0;
                        r_k     <= STEP_W'(Q_W - 1);
                        r_state <= ST_SQRT;
                    end else begin
                        r_k <= r_k - STEP_W'(1);
                    end
                end
                ST_SQRT: begin
                    if (w_sq <= (2*Q_W)'(r_qd)) begin
                        r_q <= w_t;
                    end
                    if (r_k == '0) begin
                        r_state <= ST_OUT;
                    end else begin
                        r_k <= r_k - STEP_W'(1);
                    end
                end
                ST_OUT: begin
                    if (w_free) begin
                        r_odata.segment_valid   <= r_job.seg;
                        r_odata.correlation     <= r_job.seg ? w_corr : '0;
                        r_odata.degenerate      <= r_job.seg && r_degen;
                        r_odata.segment_index   <= r_job.seg ? r_job.index : '0;
                        r_odata.max_correlation <= w_newmax;
                        r_odata.record_done     <= r_job.last;
                        r_max   <= r_job.last ? CORR_MIN : w_newmax;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // quotient never exceeds one in Q30 by the Cauchy-Schwarz bound
    a_quot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQRT) |-> (r_qd <= (QD_W'(1) << FRAC_SHIFT)))
        else $error("quotient above one");

    // a degenerate segment reports zero
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_odata.degenerate) |-> (r_odata.correlation == '0))
        else $error("degenerate segment with nonzero correlation");

    // running maximum restarts once the end-of-record result is loaded
    a_max_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_OUT) && w_free && r_job.last) |=> (r_max == CORR_MIN))
        else $error("running maximum not restarted");

endmodule

[rtl/segmented_pearson_correlation_max.sv]
// Segmented Pearson correlation with running maximum. One sample pair is taken
// per cycle while the two-entry job queue has room. Each completed segment
// then runs through the engine in turn: the bit-serial multiplier steps
// through the bits of its second operand for each of eight products, followed
// by a bit-serial divider and a bit-serial square root; small sums finish the
// products sooner and a degenerate segment skips the last two products, the
// divider and the root. An end-of-record result without a segment goes from
// idle straight to the output state. A new job is taken only in idle, so short
// strides back-pressure the input. Write segment_length only while idle.
// depends on spcm_pkg, spcm_front, spcm_queue and spcm_back
module segmented_pearson_correlation_max
    import spcm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in              i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out             o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [LEN_W-1:0] i_cfg_data
);

    logic [LEN_W-1:0]    r_seg_len;
    logic [LEN_W-1:0]    w_len;
    logic [STRIDE_W-1:0] w_stride;
    logic                w_push, w_full, w_pop, w_empty;
    t_job                w_job_in, w_job_out;

    // configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_len <= LEN_RESET;
        end else if (i_cfg_valid) begin
            r_seg_len <= i_cfg_data;
        end
    end

    // effective length: clamped, even, at least two
    always_comb begin
        w_len = (r_seg_len > LEN_W'(MAX_SEGMENT)) ? LEN_W'(MAX_SEGMENT) : r_seg_len;
        w_len = {w_len[LEN_W-1:1], 1'b0};
        if (w_len < LEN_W'(2)) begin
            w_len = LEN_W'(2);
        end
    end

    assign w_stride = w_len[STRIDE_W:1];

    spcm_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_len    (w_len),
        .i_stride (w_stride),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_data   (i_in_data),
        .i_full   (w_full),
        .o_push   (w_push),
        .o_job    (w_job_in)
    );

    spcm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_job_out),
        .o_empty (w_empty)
    );

    spcm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .i_job   (w_job_out),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

[dv/segmented_pearson_correlation_max_tb.sv]
// testbench of segmented_pearson_correlation_max: directed and random sample records
// checked against an in-bench predictor of the segment correlation and running maximum
// depends on spcm_pkg and the rtl top level
`timescale 1ns / 1ps

module segmented_pearson_correlation_max_tb;
    import spcm_pkg::*;

    localparam int CYCLE_LIMIT = 6000000;
    localparam int DRAIN_WAIT  = 900;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    t_in              i_in_data;
    logic             o_out_valid;
    logic             i_out_ready;
    t_out             o_out_data;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [LEN_W-1:0] i_cfg_data;

    segmented_pearson_correlation_max i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // clock, period 8 ns
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // predictor state
    logic [LEN_W-1:0]   len_reg;
    int unsigned        acc_count [2];
    longint             acc_sx [2];
    longint             acc_sy [2];
    longint             acc_sxx [2];
    longint             acc_syy [2];
    longint             acc_sxy [2];
    int unsigned        rec_position;
    logic [IDX_W-1:0]   seg_number;
    logic signed [15:0] max_so_far;

    t_out expected_results[$];

    int unsigned cycle_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned result_count = 0;
    int unsigned segment_count;
    int unsigned pair_count;
    int unsigned snd_idle_pct;
    int unsigned rcv_idle_pct;

    // cycle counter and timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    // receiver stalls
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            result_count <= result_count + 1;
            if (expected_results.size() == 0) begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < 10)
                    $display("unexpected result transaction %p", o_out_data);
            end else begin
                if (o_out_data !== expected_results[0]) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("mismatch: expected %p actual %p",
                                 expected_results[0], o_out_data);
                end
                void'(expected_results.pop_front());
            end
        end
    end

    function automatic void clear_acc(int b);
        acc_count[b] = 0;
        acc_sx[b]    = 0;
        acc_sy[b]    = 0;
        acc_sxx[b]   = 0;
        acc_syy[b]   = 0;
        acc_sxy[b]   = 0;
    endfunction

    function automatic void clear_record();
        clear_acc(0);
        clear_acc(1);
        rec_position = 0;
        seg_number   = '0;
        max_so_far   = CORR_MIN;
    endfunction

    // q1.15 correlation of one accumulator set, truncated magnitude
    function automatic logic signed [15:0] segment_r(int b, output bit degen);
        logic signed [191:0] n, sx, sy, vx, vy, cov;
        logic [191:0]        cv, p, lim, t;
        logic [16:0]         q;
        n   = acc_count[b];
        sx  = acc_sx[b];
        sy  = acc_sy[b];
        vx  = n * 192'(signed'(acc_sxx[b])) - sx * sx;
        vy  = n * 192'(signed'(acc_syy[b])) - sy * sy;
        cov = n * 192'(signed'(acc_sxy[b])) - sx * sy;
        degen = (vx <= 0) || (vy <= 0);
        if (degen)
            return '0;
        cv  = (cov < 0) ? -cov : cov;
        p   = vx * vy;
        lim = (cv * cv) << 30;
        q   = 0;
        for (int bit_i = 15; bit_i >= 0; bit_i--) begin
            t = q | (17'd1 << bit_i);
            if (t * t * p <= lim)
                q = t;
        end
        if (cov < 0)
            return 16'(-$signed({1'b0, q}));
        return (q > 32767) ? CORR_MAX : 16'(q);
    endfunction

    // advance the predictor by one accepted pair
    function automatic void predict_pair(t_in item);
        int unsigned len, stride;
        int          done;
        longint      x, y;
        bit          degen;
        t_out        res;
        len = (len_reg > MAX_SEGMENT) ? MAX_SEGMENT : len_reg;
        len = len & ~1;
        if (len < 2)
            len = 2;
        stride = len / 2;
        x = item.x_sample;
        y = item.y_sample;
        done = -1;
        res = '0;
        for (int b = 0; b < 2; b++) begin
            if (!(b == 1 && rec_position < stride)) begin
                acc_count[b]++;
                acc_sx[b]  += x;
                acc_sy[b]  += y;
                acc_sxx[b] += x * x;
                acc_syy[b] += y * y;
                acc_sxy[b] += x * y;
            end
        end
        if (rec_position != 32'hFFFF_FFFF)
            rec_position++;
        for (int b = 1; b >= 0; b--)
            if (acc_count[b] >= len)
                done = b;
        if (done >= 0) begin
            res.segment_valid = 1'b1;
            res.correlation   = segment_r(done, degen);
            res.degenerate    = degen;
            res.segment_index = seg_number;
            seg_number++;
            if (!degen && res.correlation > max_so_far)
                max_so_far = res.correlation;
            clear_acc(done);
            segment_count++;
        end
        if (done >= 0 || item.last_of_record) begin
            res.max_correlation = max_so_far;
            res.record_done     = item.last_of_record;
            expected_results.push_back(res);
            if (item.last_of_record)
                clear_record();
        end
    endfunction

    // one input transaction, with optional sender gap
    task automatic send_pair(logic signed [15:0] x, logic signed [15:0] y, bit last);
        t_in item;
        item.x_sample       = x;
        item.y_sample       = y;
        item.last_of_record = last;
        if ($urandom_range(99) < snd_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        predict_pair(item);
        pair_count++;
    endtask

    // wait for the block to drain, then write segment_length
    task automatic write_length(logic [LEN_W-1:0] value);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        len_reg = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // extreme sample values, near-zero and near-perfect negative correlation
    task automatic test_extremes();
        write_length(LEN_W'(4));
        send_pair(16'sh7FFF, 16'sh7FFF, 0);
        send_pair(16'sh8000, 16'sh8000, 0);
        send_pair(16'sh7FFF, 16'sh8000, 0);
        send_pair(16'sh8000, 16'sh7FFF, 0);
        send_pair(16'sh1234, -16'sh1234, 0);
        send_pair(-16'sh0001, 16'sh0001, 1);
        send_pair(16'sh5555, 16'shAAAA, 1);
    endtask

    // segments with constant x or constant y are degenerate
    task automatic test_degenerate();
        write_length(LEN_W'(2));
        send_pair(16'sh0100, 16'sh0005, 0);
        send_pair(16'sh0100, -16'sh0007, 0);
        send_pair(16'sh0003, 16'sh0009, 0);
        send_pair(-16'sh0003, 16'sh0009, 1);
    endtask

    // clamping of odd and small lengths
    task automatic test_lengths();
        write_length(LEN_W'(0));
        send_pair(16'sh0010, 16'sh0020, 0);
        send_pair(16'sh0011, 16'sh0030, 1);
        write_length(LEN_W'(7));
        for (int i = 0; i < 6; i++)
            send_pair(16'(i * 311 - 900), 16'(i * i * 17), 0);
        write_length(LEN_W'(3));
        send_pair(16'sh0400, -16'sh0200, 0);
        send_pair(16'sh0100, 16'sh0700, 0);
        send_pair(-16'sh0100, 16'sh0020, 1);
    endtask

    // a length written above the clamp, then one record with a long segment
    task automatic test_long_segment();
        logic signed [15:0] x;
        write_length(LEN_W'(8191));
        for (int i = 0; i < 40; i++)
            send_pair(16'($urandom), 16'($urandom), i == 39);
        write_length(LEN_W'(512));
        for (int i = 0; i < 560; i++) begin
            x = 16'($urandom);
            send_pair(x, 16'(x / 2 + $signed(16'($urandom_range(0, 4000))) - 2000),
                      i == 559);
        end
    endtask

    // random records with well-formed framing and some noise
    task automatic test_random(int unsigned n_items);
        int unsigned start, rec_len, seg, kind;
        logic signed [15:0] x, y, base;
        start = pair_count;
        while (pair_count - start < n_items) begin
            case ($urandom_range(9))
                0:       seg = $urandom_range(0, 8191) & 13'h007F;
                1:       seg = $urandom_range(0, 8191);
                default: seg = $urandom_range(2, 24);
            endcase
            if (seg > 200)
                seg = (seg & 13'h1000) | (seg & 13'h003F);
            write_length(LEN_W'(seg));
            seg = (seg > MAX_SEGMENT) ? MAX_SEGMENT : seg;
            seg = (seg < 2) ? 2 : seg;
            for (int r = 0; r < $urandom_range(1, 3); r++) begin
                rec_len = (seg > 64) ? $urandom_range(1, 40)
                                     : $urandom_range(1, 4 * seg + 6);
                kind = $urandom_range(4);
                base = 16'($urandom);
                for (int i = 0; i < rec_len; i++) begin
                    x = 16'($urandom);
                    case (kind)
                        0: y = 16'($urandom);
                        1: y = x;
                        2: y = -x;
                        3: y = 16'(x / 4 + $signed(16'($urandom_range(0, 255))));
                        default: begin
                            x = base;
                            y = ($urandom_range(1)) ? base : 16'($urandom);
                        end
                    endcase
                    if ($urandom_range(19) == 0)
                        x = ($urandom_range(1)) ? 16'sh7FFF : 16'sh8000;
                    send_pair(x, y, (i == rec_len - 1) || ($urandom_range(99) == 0));
                end
            end
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        segment_count  = 0;
        pair_count     = 0;
        snd_idle_pct   = 29;
        rcv_idle_pct   = 87;
        len_reg        = LEN_RESET;
        clear_record();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset length of 256 with a short record first
        for (int i = 0; i < 3; i++)
            send_pair(16'($urandom), 16'($urandom), i == 2);
        test_extremes();
        test_degenerate();
        test_lengths();
        test_long_segment();

        test_random(275);
        snd_idle_pct = 87;
        rcv_idle_pct = 29;
        test_random(275);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        test_random(275);

        // drain
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("sent %0d sample pairs, %0d segments, %0d result transactions checked",
                 pair_count, segment_count, result_count);
        $display("lengths from 0 to 8191 with three stall mixes, %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/spcm_pkg.sv
rtl/spcm_front.sv
rtl/spcm_queue.sv
rtl/spcm_back.sv
rtl/segmented_pearson_correlation_max.sv
dv/segmented_pearson_correlation_max_tb.sv
